/* rtl/core/osfe_pkg.sv */
// shared types, constants and digest key table for the sensor frame encoder
`default_nettype none

package osfe_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_CHANNEL     = 3'd0;
  localparam logic [2:0] CFG_SENSOR_ID   = 3'd1;
  localparam logic [2:0] CFG_MODEL_BYTE  = 3'd2;
  localparam logic [2:0] CFG_HUMIDITY    = 3'd3;
  localparam logic [2:0] CFG_LOW_BATTERY = 3'd4;

  // reset values of the configuration registers
  localparam logic [2:0] RST_CHANNEL     = 3'd3;
  localparam logic [7:0] RST_SENSOR_ID   = 8'd65;
  localparam logic [7:0] RST_MODEL_BYTE  = 8'd70;
  localparam logic [7:0] RST_HUMIDITY    = 8'd50;
  localparam logic       RST_LOW_BATTERY = 1'b0;

  localparam int MSG_BITS    = 48;
  localparam int DIGEST_BITS = 40;
  localparam int FRAME_BITS  = 192;
  localparam int FRAME_BYTES = 24;

  localparam logic [4:0] LAST_INDEX = 5'(FRAME_BYTES - 1);

  // frame leads
  localparam logic [11:0] LEAD_FIRST  = 12'h001;
  localparam logic [14:0] LEAD_REPEAT = 15'h1FFD;

  // lfsr digest
  localparam logic [7:0] DIGEST_GEN = 8'h98;
  localparam logic [7:0] DIGEST_KEY = 8'h3e;
  localparam logic [7:0] DIGEST_XOR = 8'h64;

  // raw = floor(T*18/100) + 720, done as floor((T*18 + 72000) / 100)
  localparam logic signed [20:0] RAW_OFFSET = 21'sd72000;
  localparam logic signed [20:0] RAW_SAT    = 21'sd409600;
  localparam logic [18:0]        RAW_SAT_N  = 19'd409599;
  localparam logic [19:0]        DIV100_MUL   = 20'd671089;
  localparam int                 DIV100_SHIFT = 26;

  typedef struct packed {
    logic       low_battery;
    logic [2:0] channel;
    logic [7:0] sensor_id;
    logic [7:0] model_byte;
    logic [7:0] humidity;
  } cfg_t;

  // key used for each message bit, first bit at entry 0
  function automatic logic [DIGEST_BITS-1:0][7:0] gen_digest_keys();
    logic [7:0]                    k;
    logic [DIGEST_BITS-1:0][7:0]   tbl;
    k = DIGEST_KEY;
    for (int j = 0; j < DIGEST_BITS; j++) begin
      tbl[j] = k;
      k = k[0] ? ((k >> 1) ^ DIGEST_GEN) : (k >> 1);
    end
    return tbl;
  endfunction

  localparam logic [DIGEST_BITS-1:0][7:0] DIGEST_KEYS = gen_digest_keys();

endpackage

`default_nettype wire

/* rtl/core/ook_sensor_frame_encoder_top.sv */
// top level of the ook sensor frame encoder
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_ready    in_water_temp_centi (s16)
//  out      output     out_valid / out_ready  out_frame_byte, out_byte_index, out_last_byte
//  cfg      input      cfg_valid / cfg_ready  cfg_index (3), cfg_data (8)
//
// each reading gives 24 frame bytes, one per cycle while out_ready is high;
// the byte serialiser in the back end sets that rate; after the reading's
// transaction its first byte passes the two scaling stages, the queue, the
// frame register and the output register
// the front takes a new reading while the back is still sending; up to
// QUEUE_DEPTH messages wait in between or in the scaling stages, then in_ready drops
// synchronous active-low reset; configuration returns to its reset values
`default_nettype none

module ook_sensor_frame_encoder_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_water_temp_centi,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_frame_byte,
  output logic [4:0]         out_byte_index,
  output logic               out_last_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [7:0]         cfg_data
);
  import osfe_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cfg_t                cfg_r, cfg_nxt;
  logic [CW-1:0]       q_count;
  logic                push;
  logic [MSG_BITS-1:0] push_msg;
  logic                q_pop;
  logic [MSG_BITS-1:0] q_msg;

  // configuration writes are always taken; unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_CHANNEL:     cfg_nxt.channel     = cfg_data[2:0];
        CFG_SENSOR_ID:   cfg_nxt.sensor_id   = cfg_data;
        CFG_MODEL_BYTE:  cfg_nxt.model_byte  = cfg_data;
        CFG_HUMIDITY:    cfg_nxt.humidity    = cfg_data;
        CFG_LOW_BATTERY: cfg_nxt.low_battery = cfg_data[0];
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.channel     <= RST_CHANNEL;
      cfg_r.sensor_id   <= RST_SENSOR_ID;
      cfg_r.model_byte  <= RST_MODEL_BYTE;
      cfg_r.humidity    <= RST_HUMIDITY;
      cfg_r.low_battery <= RST_LOW_BATTERY;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // scaling, message build and digest
  osfe_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .CW         (CW)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_water_temp_centi(in_water_temp_centi),
    .cfg                (cfg_r),
    .q_count            (q_count),
    .push               (push),
    .push_msg           (push_msg)
  );

  // finished messages waiting for the serialiser
  osfe_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .CW         (CW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_msg(push_msg),
    .pop     (q_pop),
    .pop_msg (q_msg),
    .count   (q_count)
  );

  // frame layout and byte output
  osfe_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_count != '0),
    .q_msg         (q_msg),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_frame_byte(out_frame_byte),
    .out_byte_index(out_byte_index),
    .out_last_byte (out_last_byte)
  );

  // queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("message queue overflow");

  // flow control leaves room for every message already in the scaling stages
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push && !q_pop |-> q_count < CW'(QUEUE_DEPTH))
    else $error("push into a full queue");

  // the flag marks only the final byte of a frame
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_byte |-> out_byte_index == LAST_INDEX)
    else $error("last byte flag on wrong index");

  // bytes of one frame follow each other with no gap
  a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_byte |=>
      out_valid && (out_byte_index == 5'($past(out_byte_index) + 5'd1)))
    else $error("frame bytes out of sequence");

endmodule

`default_nettype wire

/* rtl/core/osfe_front.sv */
// front end: accepts readings, scales to raw, builds message with digest
`default_nettype none

module osfe_front #(
  parameter int QUEUE_DEPTH = 4,
  parameter int CW          = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [15:0]          in_water_temp_centi,
  input  osfe_pkg::cfg_t              cfg,
  input  logic [CW-1:0]               q_count,
  output logic                        push,
  output logic [osfe_pkg::MSG_BITS-1:0] push_msg
);
  import osfe_pkg::*;

  logic signed [20:0] t_ext;
  logic signed [20:0] v;
  logic [18:0]        n_nxt;
  logic [18:0]        n_r;
  logic               s1_v_r;
  logic [38:0]        prod_nxt;
  logic [38:0]        prod_r;
  logic               s2_v_r;
  logic [11:0]        raw;
  logic [DIGEST_BITS-1:0] msg40;
  logic [7:0]         dig;
  logic [CW:0]        occupied;

  // room for everything already in flight plus this one
  assign occupied = {1'b0, q_count} + (CW+1)'(s1_v_r) + (CW+1)'(s2_v_r);
  assign in_ready = occupied < (CW+1)'(QUEUE_DEPTH);

  always_comb begin
    t_ext = {{5{in_water_temp_centi[15]}}, in_water_temp_centi};
    v     = (t_ext <<< 4) + (t_ext <<< 1) + RAW_OFFSET;
    if (v < 0) begin
      n_nxt = '0;
    end else if (v >= RAW_SAT) begin
      n_nxt = RAW_SAT_N;
    end else begin
      n_nxt = v[18:0];
    end
  end

  assign prod_nxt = {20'd0, n_r} * {19'd0, DIV100_MUL};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid & in_ready;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid & in_ready) begin
      n_r <= n_nxt;
    end
    prod_r <= prod_nxt;
  end

  always_comb begin
    raw   = prod_r[DIV100_SHIFT +: 12];
    msg40 = {cfg.model_byte, cfg.sensor_id,
             cfg.low_battery, cfg.channel, raw[11:8],
             raw[7:0], cfg.humidity};
    dig = DIGEST_XOR;
    for (int j = 0; j < DIGEST_BITS; j++) begin
      if (msg40[DIGEST_BITS-1-j]) begin
        dig = dig ^ DIGEST_KEYS[j];
      end
    end
  end

  assign push     = s2_v_r;
  assign push_msg = {msg40, dig};

endmodule

`default_nettype wire

/* rtl/core/osfe_queue.sv */
// small message queue between front and back
`default_nettype none

module osfe_queue #(
  parameter int QUEUE_DEPTH = 4,
  parameter int CW          = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  logic [osfe_pkg::MSG_BITS-1:0] push_msg,
  input  logic                          pop,
  output logic [osfe_pkg::MSG_BITS-1:0] pop_msg,
  output logic [CW-1:0]                 count
);
  import osfe_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [MSG_BITS-1:0] mem_r [QUEUE_DEPTH];
  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_msg;
    end
  end

  assign pop_msg = mem_r[rd_ptr_r];
  assign count   = count_r;

endmodule

`default_nettype wire

/* rtl/core/osfe_back.sv */
// back end: lays out the frame and serialises it one byte per cycle while out_ready is high
`default_nettype none

module osfe_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  logic [osfe_pkg::MSG_BITS-1:0] q_msg,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_frame_byte,
  output logic [4:0]                    out_byte_index,
  output logic                          out_last_byte
);
  import osfe_pkg::*;

  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [4:0]            idx_r, idx_nxt;
  logic                  busy_r, busy_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            byte_r, byte_nxt;
  logic [4:0]            oidx_r, oidx_nxt;
  logic                  last_r, last_nxt;
  logic                  advance;
  logic                  emit;
  logic                  load;

  assign advance = !out_valid_r || out_ready;
  assign emit    = busy_r && advance;
  assign load    = q_valid && (!busy_r || (emit && idx_r == LAST_INDEX));
  assign q_pop   = load;

  always_comb begin
    frame_nxt     = frame_r;
    idx_nxt       = idx_r;
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    oidx_nxt      = oidx_r;
    last_nxt      = last_r;
    if (advance) begin
      out_valid_nxt = busy_r;
      byte_nxt      = frame_r[FRAME_BITS-1 -: 8];
      oidx_nxt      = idx_r;
      last_nxt      = (idx_r == LAST_INDEX);
    end
    if (emit) begin
      frame_nxt = frame_r << 8;
      idx_nxt   = idx_r + 5'd1;
      if (idx_r == LAST_INDEX) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      frame_nxt = {LEAD_FIRST, q_msg, 2'b00,
                   LEAD_REPEAT, q_msg, 2'b00,
                   LEAD_REPEAT, q_msg, 2'b00};
      idx_nxt   = '0;
      busy_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    byte_r  <= byte_nxt;
    oidx_r  <= oidx_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = byte_r;
  assign out_byte_index = oidx_r;
  assign out_last_byte  = last_r;

endmodule

`default_nettype wire
